/* rtl/bfm_pkg.sv */
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types, constants and the byte-wide CRC-32 step for the Bloom filter
// membership unit.
// ----------------------------------------------------------------------------
package bfm_pkg;

	localparam int CRC_W        = 32;
	localparam int BYTE_W       = 8;
	localparam int ROW_W        = 8;
	localparam int BIT_OFF_W    = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 31;
	localparam int NUM_BITS_W   = 17;
	localparam int NUM_HASHES_W = 4;
	localparam int SEED_W       = 31;
	localparam int COUNT_W      = 32;

	localparam logic [CRC_W-1:0]        CRC_POLY       = 32'hEDB8_8320;
	localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RST   = 17'd65536;
	localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RST = 4'd4;
	localparam logic [COUNT_W-1:0]      COUNT_MAX      = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_BITS   = 2'd0,
		CFG_NUM_HASHES = 2'd1,
		CFG_HASH_SEED  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_MOD,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_QUERY  = 1'b1
	} kind_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	typedef struct packed {
		logic     key_stall;
		logic     mod_start;
		logic     res_load;
		mem_cmd_t mem;
	} ctrl_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ CRC_W'(data);
		for (int b = 0; b < BYTE_W; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* rtl/bfm_crc_lanes.sv */
// ----------------------------------------------------------------------------
// bfm_crc_lanes
// One running CRC-32 register per hash lane, seeded at the start of a key and
// advanced by one key byte per accepted word when use_byte is set.
// ----------------------------------------------------------------------------
module bfm_crc_lanes
	import bfm_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     seed_sel,
	input  logic                     use_byte,
	input  logic [BYTE_W-1:0]        key_byte,
	input  logic [SEED_W-1:0]        hash_seed,
	output logic [CRC_W-1:0]         crc [LANES]
);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [CRC_W-1:0] base;
		logic [CRC_W-1:0] nxt;

		always_comb begin
			base = seed_sel ? ~(CRC_W'(hash_seed) + CRC_W'(i)) : crc[i];
			nxt  = use_byte ? crc_byte(base, key_byte) : base;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				crc[i] <= nxt;
			end
		end
	end

endmodule

/* rtl/bfm_mod_unit.sv */
// ----------------------------------------------------------------------------
// bfm_mod_unit
// Restoring remainder unit: reduces a 32-bit hash modulo the filter size,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bfm_mod_unit
	import bfm_pkg::*;
#(
	parameter int IW = 16,
	parameter int MW = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CRC_W-1:0]  dividend,
	input  logic [MW-1:0]     modulus,
	output logic              busy,
	output logic              done,
	output logic [IW-1:0]     rem
);

	localparam int CNT_W = $clog2(CRC_W);
	localparam int RW    = IW + 1;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CRC_W - 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [IW-1:0]    rem_q;
	logic [CRC_W-1:0] dvd_q;
	logic [RW-1:0]    shifted;
	logic [RW-1:0]    mod_ext;
	logic [RW-1:0]    rem_nxt;

	always_comb begin
		shifted = {rem_q, dvd_q[CRC_W-1]};
		mod_ext = RW'(modulus);
		rem_nxt = (shifted >= mod_ext) ? (shifted - mod_ext) : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt[IW-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* rtl/bfm_filter_store.sv */
// ----------------------------------------------------------------------------
// bfm_filter_store
// Filter bit memory, eight bits a row, with a registered read port. Sweeps
// every row to zero after reset.
// ----------------------------------------------------------------------------
module bfm_filter_store
	import bfm_pkg::*;
#(
	parameter int ROWS   = 8192,
	parameter int ROW_AW = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_cmd_t          cmd,
	input  logic [ROW_AW-1:0] addr,
	input  logic [ROW_W-1:0]  wdata,
	output logic [ROW_W-1:0]  rdata,
	output logic              clear_busy
);

	localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

	logic [ROW_W-1:0]  mem [ROWS];
	logic [ROW_W-1:0]  rdata_q;
	logic              clr_q;
	logic [ROW_AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ROW_AW'(1);
			if (clr_addr_q == LAST_ROW) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.wr) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata      = rdata_q;
	assign clear_busy = clr_q;

endmodule

/* rtl/bloom_filter_membership_unit.sv */
// ----------------------------------------------------------------------------
// bloom_filter_membership_unit
// Bloom filter over a bit memory of MAX_BITS bits. Keys stream in one byte per
// word, and MAX_HASHES CRC-32 lanes advance together on each byte. The word
// that ends a key (key_last or empty_key) starts the probe phase, in which
// the key's kind decides insert or query: for each of the num_hashes lanes
// the hash is reduced modulo num_bits by a bit-serial remainder unit, then
// the filter row is read and checked and, for an insert, written back with
// the hash's bit set. One result word per key is held in an output register,
// and the next key is taken while it waits. After reset the memory is swept
// to zero one 8-bit row per cycle over ceil(MAX_BITS / 8) rows, while no key
// word is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module bloom_filter_membership_unit
	import bfm_pkg::*;
#(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  key_valid,
	output logic                  key_stall,
	input  logic                  kind,
	input  logic [BYTE_W-1:0]     key_byte,
	input  logic                  key_last,
	input  logic                  empty_key,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  done_kind,
	output logic                  present,
	output logic [COUNT_W-1:0]    inserted_count
);

	localparam int IW     = $clog2(MAX_BITS);
	localparam int MW     = $clog2(MAX_BITS + 1);
	localparam int HW     = $clog2(MAX_HASHES + 1);
	localparam int HIW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
	localparam int ROWS   = (MAX_BITS + ROW_W - 1) / ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

	state_t state_q;
	state_t state_nxt;
	ctrl_t  ctrl;

	logic [NUM_BITS_W-1:0]   num_bits_q;
	logic [NUM_HASHES_W-1:0] num_hashes_q;
	logic [SEED_W-1:0]       hash_seed_q;

	logic              in_key_q;
	logic              kind_q;
	logic [MW-1:0]     m_q;
	logic [HW-1:0]     k_q;
	logic [HIW-1:0]    h_q;
	logic              present_q;
	logic [COUNT_W-1:0] insert_total_q;

	logic               res_valid_q;
	logic               done_kind_q;
	logic               present_out_q;
	logic [COUNT_W-1:0] count_out_q;

	logic               key_acc;
	logic               key_end;
	logic               res_free;
	logic               last_hash;
	logic [MW-1:0]      eff_bits;
	logic [HW-1:0]      eff_hashes;
	logic [COUNT_W-1:0] total_nxt;

	logic [CRC_W-1:0]   crc [MAX_HASHES];
	logic               mod_busy;
	logic               mod_done;
	logic [IW-1:0]      rem;
	logic [ROW_W-1:0]   rdata;
	logic [ROW_W-1:0]   bit_mask;
	logic               bit_set;
	logic [ROW_AW-1:0]  row_addr;
	logic               clear_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bits_q   <= NUM_BITS_RST;
			num_hashes_q <= NUM_HASHES_RST;
			hash_seed_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NUM_BITS:   num_bits_q   <= cfg_data[NUM_BITS_W-1:0];
				CFG_NUM_HASHES: num_hashes_q <= cfg_data[NUM_HASHES_W-1:0];
				CFG_HASH_SEED:  hash_seed_q  <= cfg_data[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_bits_q == '0) begin
			eff_bits = MW'(1);
		end else if (32'(num_bits_q) > 32'(MAX_BITS)) begin
			eff_bits = MW'(MAX_BITS);
		end else begin
			eff_bits = MW'(num_bits_q);
		end
		if (num_hashes_q == '0) begin
			eff_hashes = HW'(1);
		end else if (32'(num_hashes_q) > 32'(MAX_HASHES)) begin
			eff_hashes = HW'(MAX_HASHES);
		end else begin
			eff_hashes = HW'(num_hashes_q);
		end
	end

	assign key_end   = key_last | empty_key;
	assign key_acc   = key_valid && !ctrl.key_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign last_hash = (32'(h_q) + 32'd1) == 32'(k_q);
	assign row_addr  = ROW_AW'(rem >> BIT_OFF_W);
	assign bit_mask  = ROW_W'(1) << rem[BIT_OFF_W-1:0];
	assign bit_set   = rdata[rem[BIT_OFF_W-1:0]];
	assign total_nxt = (kind_q == KIND_INSERT && insert_total_q != COUNT_MAX) ?
		insert_total_q + COUNT_W'(1) : insert_total_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR:  if (!clear_busy) state_nxt = ST_IDLE;
			ST_IDLE:   if (key_acc && key_end) state_nxt = ST_LOAD;
			ST_LOAD:   state_nxt = ST_MOD;
			ST_MOD:    if (mod_done) state_nxt = ST_CHECK;
			ST_CHECK:  state_nxt = last_hash ? ST_FINISH : ST_LOAD;
			ST_FINISH: if (res_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.key_stall = 1'b1;
		case (state_q)
			ST_IDLE:   ctrl.key_stall = 1'b0;
			ST_LOAD:   ctrl.mod_start = 1'b1;
			ST_MOD:    ctrl.mem.rd    = mod_done;
			ST_CHECK:  ctrl.mem.wr    = (kind_q == KIND_INSERT);
			ST_FINISH: ctrl.res_load  = res_free;
			default: ;
		endcase
	end

	assign key_stall = ctrl.key_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			in_key_q       <= 1'b0;
			h_q            <= '0;
			insert_total_q <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (key_acc) begin
				in_key_q <= !key_end;
				if (key_end) begin
					h_q <= '0;
				end
			end
			if (state_q == ST_CHECK && !last_hash) begin
				h_q <= h_q + HIW'(1);
			end
			if (ctrl.res_load) begin
				insert_total_q <= total_nxt;
				res_valid_q    <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_acc && key_end) begin
			kind_q    <= kind;
			m_q       <= eff_bits;
			k_q       <= eff_hashes;
			present_q <= 1'b1;
		end else if (state_q == ST_CHECK && kind_q == KIND_QUERY && !bit_set) begin
			present_q <= 1'b0;
		end
		if (ctrl.res_load) begin
			done_kind_q   <= kind_q;
			present_out_q <= (kind_q == KIND_QUERY) & present_q;
			count_out_q   <= total_nxt;
		end
	end

	assign res_valid      = res_valid_q;
	assign done_kind      = done_kind_q;
	assign present        = present_out_q;
	assign inserted_count = count_out_q;

	bfm_crc_lanes #(
		.LANES(MAX_HASHES)
	) u_crc_lanes (
		.clk      (clk),
		.en       (key_acc),
		.seed_sel (!in_key_q),
		.use_byte (!empty_key),
		.key_byte (key_byte),
		.hash_seed(hash_seed_q),
		.crc      (crc)
	);

	bfm_mod_unit #(
		.IW(IW),
		.MW(MW)
	) u_mod_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctrl.mod_start),
		.dividend(~crc[h_q]),
		.modulus (m_q),
		.busy    (mod_busy),
		.done    (mod_done),
		.rem     (rem)
	);

	bfm_filter_store #(
		.ROWS  (ROWS),
		.ROW_AW(ROW_AW)
	) u_filter_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctrl.mem),
		.addr      (row_addr),
		.wdata     (rdata | bit_mask),
		.rdata     (rdata),
		.clear_busy(clear_busy)
	);

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mem.wr |-> !clear_busy)
		else $error("filter write during clearing sweep");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mod_start |-> !mod_busy)
		else $error("remainder unit restarted while busy");

	a_key_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		key_acc |-> (!mod_busy && !clear_busy))
		else $error("key word taken during probe or clear");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> insert_total_q >= $past(insert_total_q))
		else $error("insert count decreased");

endmodule
